>>> src/b64d_pkg.sv
// Shared types, constants and the character decode function for the
// base64url stream decoder. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

   localparam logic [11:0] MAX_CHARS_RESET = 12'd2048;
   localparam logic [11:0] COUNT_MAX       = 12'hfff;
   localparam int          QUEUE_DEPTH     = 4;

   localparam logic [5:0]  SEXTET_DASH     = 6'd62;
   localparam logic [5:0]  SEXTET_UNDER    = 6'd63;

   localparam logic [1:0]  ST_OK           = 2'd0;
   localparam logic [1:0]  ST_BAD_CHAR     = 2'd1;
   localparam logic [1:0]  ST_TOO_LONG     = 2'd2;

   localparam logic        KIND_DATA       = 1'b0;
   localparam logic        KIND_CLOSE      = 1'b1;

   localparam logic        REG_MAX_CHARS   = 1'b0;

   // One queue entry: the data bytes of a finished group and the closing result.
   typedef struct packed {
      logic [1:0]  nbytes;
      logic [23:0] word;
      logic        close;
      logic [1:0]  status;
      logic [11:0] count;
   } b64d_job_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] v;
      v = 6'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = 6'(c - 8'd65);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = 6'(c - 8'd71);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 6'(c + 8'd4);
      end else if (c == 8'h2d) begin
         v = SEXTET_DASH;
      end else if (c == 8'h5f) begin
         v = SEXTET_UNDER;
      end
      return v;
   endfunction

endpackage

>>> src/b64d_front.sv
// Front end: one character a cycle while the queue has room; packs sextets
// into groups, tracks length, errors, queues finished groups. Uses b64d_pkg.
`timescale 1ns / 1ps

module b64d_front
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [7:0]   req_symbol,
   input  logic         req_last_char,
   input  logic [11:0]  max_chars,
   input  logic         queue_full,
   output logic         req_ready,
   output logic         push,
   output b64d_job_type job
);

   logic [17:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_pos_ff, group_pos_in;
   logic [11:0] char_count_ff, char_count_in;
   logic [11:0] bytes_ff, bytes_in;
   logic [1:0]  error_ff, error_in;

   logic        accept;
   logic [5:0]  val;
   logic [1:0]  err_a, err_b;
   logic [2:0]  pos;
   logic [1:0]  nb, emit_nb;
   logic [23:0] word;
   logic [12:0] bytes_sum;
   logic [11:0] bytes_next;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      val   = req_symbol[7] ? 6'd0 : sextet_of(req_symbol);
      err_a = (req_symbol[7] && error_ff == ST_OK) ? ST_BAD_CHAR : error_ff;
      // The length check looks at the count before this character.
      err_b = (char_count_ff >= max_chars) ? ST_TOO_LONG : err_a;
      pos   = {1'b0, group_pos_ff} + 3'd1;

      if (pos == 3'd4) begin
         nb = 2'd3;
      end else if (req_last_char) begin
         nb = (pos == 3'd3) ? 2'd2 : 2'd1;
      end else begin
         nb = 2'd0;
      end

      case (pos)
         3'd1:    word = {val, 18'd0};
         3'd2:    word = {group_bits_ff[5:0], val, 12'd0};
         3'd3:    word = {group_bits_ff[11:0], val, 6'd0};
         default: word = {group_bits_ff, val};
      endcase

      emit_nb    = (err_b == ST_OK) ? nb : 2'd0;
      bytes_sum  = {1'b0, bytes_ff} + {11'd0, emit_nb};
      bytes_next = bytes_sum[12] ? COUNT_MAX : bytes_sum[11:0];

      job.nbytes = emit_nb;
      job.word   = word;
      job.close  = req_last_char;
      job.status = err_b;
      job.count  = bytes_next;

      push = accept && (emit_nb != 2'd0 || req_last_char);
   end

   always_comb begin
      group_bits_in = group_bits_ff;
      group_pos_in  = group_pos_ff;
      char_count_in = char_count_ff;
      bytes_in      = bytes_ff;
      error_in      = error_ff;
      if (accept) begin
         if (req_last_char) begin
            group_bits_in = 18'd0;
            group_pos_in  = 2'd0;
            char_count_in = 12'd0;
            bytes_in      = 12'd0;
            error_in      = ST_OK;
         end else begin
            char_count_in = (char_count_ff == COUNT_MAX) ? COUNT_MAX
                                                         : char_count_ff + 12'd1;
            bytes_in      = bytes_next;
            error_in      = err_b;
            if (nb != 2'd0) begin
               group_bits_in = 18'd0;
               group_pos_in  = 2'd0;
            end else begin
               group_bits_in = {group_bits_ff[11:0], val};
               group_pos_in  = pos[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff <= 18'd0;
         group_pos_ff  <= 2'd0;
         char_count_ff <= 12'd0;
         bytes_ff      <= 12'd0;
         error_ff      <= ST_OK;
      end else begin
         group_bits_ff <= group_bits_in;
         group_pos_ff  <= group_pos_in;
         char_count_ff <= char_count_in;
         bytes_ff      <= bytes_in;
         error_ff      <= error_in;
      end
   end

endmodule

>>> src/b64d_queue.sv
// Small job queue between the front and back ends so that each side can
// stall on its own. Uses b64d_pkg for the entry type.
`timescale 1ns / 1ps

module b64d_queue
   import b64d_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64d_job_type push_data,
   input  logic         pop,
   output logic         not_empty,
   output logic         full,
   output b64d_job_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   b64d_job_type    entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CntW'(Depth));
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with the fill count");
`endif

endmodule

>>> src/b64d_back.sv
// Back end: unrolls each queued job into data-byte words and any closing
// word, one word a cycle into the output register when free. Uses b64d_pkg.
`timescale 1ns / 1ps

module b64d_back
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  b64d_job_type job,
   output logic         pop,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_kind,
   output logic [7:0]   rsp_out_byte,
   output logic [1:0]   rsp_status,
   output logic [11:0]  rsp_byte_count,
   output logic         rsp_end_of_string
);

   b64d_job_type cur_ff, cur_in;
   logic         cur_valid_ff, cur_valid_in;
   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_kind_ff;
   logic [7:0]   rsp_byte_ff;
   logic [1:0]   rsp_status_ff;
   logic [11:0]  rsp_count_ff;
   logic         rsp_eos_ff;

   logic         out_free, load, last_word, is_data;
   logic [2:0]   total;
   logic [7:0]   data_byte;

   always_comb begin
      total     = {1'b0, cur_ff.nbytes} + {2'd0, cur_ff.close};
      last_word = ({1'b0, idx_ff} == total - 3'd1);
      is_data   = (idx_ff < cur_ff.nbytes);
      out_free  = !rsp_valid_ff || rsp_ready;
      load      = out_free && cur_valid_ff;
      // The next job is fetched in the same cycle the current one finishes.
      pop       = job_valid && (!cur_valid_ff || (load && last_word));

      case (idx_ff)
         2'd0:    data_byte = cur_ff.word[23:16];
         2'd1:    data_byte = cur_ff.word[15:8];
         default: data_byte = cur_ff.word[7:0];
      endcase

      cur_in       = pop ? job : cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (load && last_word) begin
         cur_valid_in = 1'b0;
         idx_in       = 2'd0;
      end else if (load) begin
         idx_in = idx_ff + 2'd1;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load) begin
         rsp_kind_ff   <= is_data ? KIND_DATA : KIND_CLOSE;
         rsp_byte_ff   <= is_data ? data_byte : 8'd0;
         rsp_status_ff <= is_data ? ST_OK : cur_ff.status;
         rsp_count_ff  <= is_data ? 12'd0 : cur_ff.count;
         rsp_eos_ff    <= !is_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_byte_count    = rsp_count_ff;
   assign rsp_end_of_string = rsp_eos_ff;

`ifndef NO_ASSERTIONS
   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      (load && !is_data) |-> last_word)
      else $error("closing word is not the last word of its job");
   a_data_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DATA) |->
      (rsp_status == ST_OK && rsp_byte_count == 12'd0 && !rsp_end_of_string))
      else $error("data word carries closing fields");
`endif

endmodule

>>> src/base64url_stream_decoder_core.sv
// Top level of the base64url stream decoder: register port, front end,
// job queue and back end. Uses b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   Channel   Ports    Direction   Carries
//   request   req_*    in          one character and its last-character flag
//   response  rsp_*    out         one decoded byte or the closing status word
//   register  csr_*    in/out      max_chars at byte address 0
//
// The front end takes one character per cycle as long as the job queue has
// room; each character decodes in the cycle it is accepted.
// The back end sends one word per cycle from its output register while
// rsp_ready allows; four characters give three words, a string's end one more.
// The queue holds QueueDepth jobs, which lets either side stall on its own.
// Reset clears all string state and sets max_chars to 2048; no clearing pass.
`timescale 1ns / 1ps

module base64url_stream_decoder_core
   import b64d_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_symbol,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_byte_count,
   output logic        rsp_end_of_string,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [11:0]  max_chars_ff, max_chars_in;
   logic         csr_write;
   logic         queue_full, queue_not_empty, push, pop;
   b64d_job_type push_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_CHARS) ? {20'd0, max_chars_ff} : 32'd0;

   always_comb begin
      max_chars_in = max_chars_ff;
      if (csr_write && csr_paddr[2] == REG_MAX_CHARS) begin
         max_chars_in = csr_pwdata[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   b64d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_symbol    (req_symbol),
      .req_last_char (req_last_char),
      .max_chars     (max_chars_ff),
      .queue_full    (queue_full),
      .req_ready     (req_ready),
      .push          (push),
      .job           (push_job)
   );

   b64d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .head      (head_job)
   );

   b64d_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (queue_not_empty),
      .job               (head_job),
      .pop               (pop),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule

>>> test/b64d_decode_checker.sv
// Checker for the base64url stream decoder: watches the request, response and
// register ports, predicts every response word and compares it on arrival.
// Depends on b64d_pkg for status, kind and register codes.
`timescale 1ns / 1ps

module b64d_decode_checker
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_symbol,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_out_byte,
   input  logic [1:0]  rsp_status,
   input  logic [11:0] rsp_byte_count,
   input  logic        rsp_end_of_string,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          words_pending
);

   localparam logic [2:0] ADDR_MAX_CHARS = {REG_MAX_CHARS, 2'b00};
   localparam int         REPORT_LIMIT   = 10;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic [11:0] byte_count;
      logic        eos;
   } decoded_word_type;

   decoded_word_type expected_words[$];

   logic [11:0] limit_chars;
   logic [17:0] group_bits;
   logic [1:0]  group_pos;
   logic [11:0] char_count;
   logic [11:0] bytes_sent;
   logic [1:0]  string_status;

   function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
         return 6'(c - "a" + 8'd26);
      end else if (c >= "0" && c <= "9") begin
         return 6'(c - "0" + 8'd52);
      end else if (c == "-") begin
         return SEXTET_DASH;
      end else if (c == "_") begin
         return SEXTET_UNDER;
      end
      return 6'd0;
   endfunction

   task automatic clear_string();
      group_bits    = '0;
      group_pos     = '0;
      char_count    = '0;
      bytes_sent    = '0;
      string_status = ST_OK;
   endtask

   task automatic push_word(input logic kind, input logic [7:0] data,
                            input logic [1:0] status, input logic [11:0] count,
                            input logic eos);
      decoded_word_type w;
      w.kind       = kind;
      w.out_byte   = data;
      w.status     = status;
      w.byte_count = count;
      w.eos        = eos;
      expected_words.push_back(w);
   endtask

   task automatic decode_char(input logic [7:0] sym, input logic last);
      logic [5:0]  value;
      logic [2:0]  filled;
      logic [23:0] group_word;
      logic [23:0] aligned;
      int          nbytes;
      int          i;
      value = sym[7] ? 6'd0 : char_to_sextet(sym);
      if (sym[7] && string_status == ST_OK) begin
         string_status = ST_BAD_CHAR;
      end
      // An overlong string wins over a bad character.
      if (char_count >= limit_chars) begin
         string_status = ST_TOO_LONG;
      end
      if (char_count != COUNT_MAX) begin
         char_count = char_count + 12'd1;
      end
      filled     = {1'b0, group_pos} + 3'd1;
      group_word = {group_bits, value};
      nbytes     = 0;
      if (filled == 3'd4) begin
         nbytes = 3;
      end else if (last) begin
         nbytes = (filled == 3'd3) ? 2 : 1;
      end
      if (nbytes != 0) begin
         aligned = group_word << (6 * (4 - filled));
         if (string_status == ST_OK) begin
            for (i = 0; i < nbytes; i++) begin
               push_word(KIND_DATA, aligned[23 - 8 * i -: 8], ST_OK, 12'd0, 1'b0);
               if (bytes_sent != COUNT_MAX) begin
                  bytes_sent = bytes_sent + 12'd1;
               end
            end
         end
         group_bits = '0;
         group_pos  = '0;
      end else begin
         group_bits = group_word[17:0];
         group_pos  = filled[1:0];
      end
      if (last) begin
         push_word(KIND_CLOSE, 8'd0, string_status, bytes_sent, 1'b1);
         clear_string();
      end
   endtask

   task automatic check_word();
      decoded_word_type want;
      if (expected_words.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: unexpected word: kind %0d byte %02h status %0d count %0d eos %0d",
                     $time, rsp_kind, rsp_out_byte, rsp_status, rsp_byte_count,
                     rsp_end_of_string);
         end
         mismatch_count++;
      end else begin
         want = expected_words.pop_front();
         if (rsp_kind !== want.kind || rsp_out_byte !== want.out_byte ||
             rsp_status !== want.status || rsp_byte_count !== want.byte_count ||
             rsp_end_of_string !== want.eos) begin
            if (mismatch_count < REPORT_LIMIT) begin
               $display("%0t: word mismatch", $time);
               $display("   expected kind %0d byte %02h status %0d count %0d eos %0d",
                        want.kind, want.out_byte, want.status, want.byte_count,
                        want.eos);
               $display("   got      kind %0d byte %02h status %0d count %0d eos %0d",
                        rsp_kind, rsp_out_byte, rsp_status, rsp_byte_count,
                        rsp_end_of_string);
            end
            mismatch_count++;
         end
      end
   endtask

   // The prediction runs before the comparison, so that each word finds its
   // expectation already queued when it is checked.
   always @(posedge clock) begin
      if (reset) begin
         mismatch_count = 0;
         limit_chars = MAX_CHARS_RESET;
         clear_string();
         expected_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_MAX_CHARS) begin
            limit_chars = csr_pwdata[11:0];
         end
         if (req_valid && req_ready) begin
            decode_char(req_symbol, req_last_char);
         end
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
      end
      words_pending = expected_words.size();
   end

endmodule

>>> test/tb_base64url_stream_decoder_core.sv
// Testbench top for the base64url stream decoder: clock, reset, character and
// register stimulus, response back-pressure and the final verdict.
// Depends on b64d_pkg, base64url_stream_decoder_core and b64d_decode_checker.
`timescale 1ns / 1ps

module tb_base64url_stream_decoder_core;
   import b64d_pkg::*;

   localparam int         CLOCK_HALF    = 6;
   localparam int         RESET_CYCLES  = 7;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         IDLE_PERCENT  = 7;
   localparam int         PHASE_ITEMS   = 64;
   localparam int         LONG_RUN      = 48;
   localparam logic [2:0] ADDR_MAX_CHARS = {REG_MAX_CHARS, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_symbol;
   logic        req_last_char;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_byte_count;
   logic        rsp_end_of_string;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int words_pending;
   int cycle_count;
   bit steady;
   bit hold_go;
   bit hold_taken;

   base64url_stream_decoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol        (req_symbol),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   b64d_decode_checker decode_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol        (req_symbol),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatch_count    (mismatch_count),
      .words_pending     (words_pending)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random stalls, one long hold-off on request.
   initial begin
      rsp_ready  = 1'b1;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   function automatic logic [7:0] alphabet_char(input int idx);
      if (idx < 26) begin
         return 8'("A" + idx);
      end else if (idx < 52) begin
         return 8'("a" + idx - 26);
      end else if (idx < 62) begin
         return 8'("0" + idx - 52);
      end else if (idx == SEXTET_DASH) begin
         return "-";
      end
      return "_";
   endfunction

   function automatic logic [7:0] pick_char(input bit clean);
      int roll;
      roll = $urandom_range(0, 99);
      if (clean || roll < 75) begin
         return alphabet_char($urandom_range(0, 63));
      end else if (roll < 90) begin
         return 8'($urandom_range(0, 127));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back characters need no idle gap.
   task automatic send_char(input logic [7:0] sym, input logic last);
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_symbol    <= sym;
      req_last_char <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string text);
      int k;
      for (k = 0; k < text.len(); k++) begin
         send_char(text[k], k == text.len() - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic write_max_chars(input logic [11:0] value);
      wait_drained();
      // Characters that produce no word may still be in flight.
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_MAX_CHARS;
      csr_pwdata  <= {20'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_long_run(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         send_char(alphabet_char($urandom_range(0, 63)), k == count - 1);
      end
   endtask

   task automatic send_random_strings(input int target);
      int sent;
      int len;
      int k;
      bit clean;
      sent = 0;
      while (sent < target) begin
         len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
         clean = $urandom_range(0, 99) < 70;
         for (k = 0; k < len; k++) begin
            send_char(pick_char(clean), k == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_symbol    = 8'd0;
      req_last_char = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      steady        = 1'b0;
      hold_go       = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default limit: full group ending a string, each leftover size,
      // unmapped codes and bytes with the top bit set.
      send_text("TWFu");
      send_text("AA");
      send_text("-_-");
      send_text("z");
      send_text("a!9");
      send_text("QUJD");
      send_char(8'hff, 1'b0);
      send_char("w", 1'b1);
      send_char(8'h80, 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'h7f, 1'b1);

      // A zero limit flags every string as too long.
      write_max_chars(12'd0);
      send_text("AB");
      send_text("ABCD");

      // Limit of one: the second character overrides a bad-character status.
      write_max_chars(12'd1);
      send_text("A");
      send_text("AB");
      send_char(8'hc0, 1'b0);
      send_char("A", 1'b1);

      // Top limit with one long string, no idling on either side.
      write_max_chars(12'd4095);
      steady = 1'b1;
      send_long_run(LONG_RUN);
      steady = 1'b0;
      send_text("Zm9v");

      write_max_chars(12'($urandom_range(1, 24)));
      hold_go = 1'b1;
      send_random_strings(PHASE_ITEMS);

      write_max_chars(12'd4095);
      send_random_strings(PHASE_ITEMS / 2);
      wait_drained();
      send_random_strings(PHASE_ITEMS / 2);

      write_max_chars(12'($urandom_range(1, 4095)));
      send_random_strings(PHASE_ITEMS);

      write_max_chars(12'($urandom_range(4, 16)));
      send_random_strings(PHASE_ITEMS);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64url_stream_decoder_core.sv
test/b64d_decode_checker.sv
test/tb_base64url_stream_decoder_core.sv
